// ----- design/khcc_pkg.sv -----
// ----------------------------------------------------------------------------
// khcc_pkg: shared definitions for the keyword hash collision checker
// Field widths, register indexes and default sizing used by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package khcc_pkg;

  // Default number of hash slots
  localparam int SLOT_COUNT_DEF = 64;

  // Datapath widths
  localparam int ACC_W    = 16;
  localparam int CHAR_W   = 8;
  localparam int MULT_W   = 9;
  localparam int STEP_W   = 8;
  localparam int OFFS_W   = 5;
  localparam int DIVR_W   = 6;
  localparam int MODU_W   = 7;
  localparam int SLOT_W   = 6;
  localparam int SPREAD_W = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_CHAR_MULT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_OFFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd4;

  // Register reset values
  localparam logic [MULT_W-1:0] MULT_RST = 9'd1;
  localparam logic [STEP_W-1:0] STEP_RST = 8'd0;
  localparam logic [OFFS_W-1:0] OFFS_RST = 5'd0;
  localparam logic [DIVR_W-1:0] DIVR_RST = 6'd1;
  localparam logic [MODU_W-1:0] MODU_RST = 7'd64;

endpackage

`default_nettype wire

// ----- design/khcc_if.sv -----
// ----------------------------------------------------------------------------
// khcc_if: valid/ready channels of the keyword hash collision checker
// Character input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Character stream, one item per character
interface khcc_in_if import khcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              word_end;
  logic              set_end;

  modport source (output valid, char_code, word_end, set_end, input ready);
  modport sink   (input valid, char_code, word_end, set_end, output ready);
endinterface

// Result stream, one item per finished word
interface khcc_out_if import khcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic                collision;
  logic [SLOT_W-1:0]   lowest_slot;
  logic [SLOT_W-1:0]   highest_slot;
  logic [SPREAD_W-1:0] spread;
  logic                set_done;

  modport source (output valid, slot, collision, lowest_slot, highest_slot, spread,
                  set_done, input ready);
  modport sink   (input valid, slot, collision, lowest_slot, highest_slot, spread,
                  set_done, output ready);
endinterface

// Configuration register writes
interface khcc_cfg_if import khcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/khcc_div.sv -----
// ----------------------------------------------------------------------------
// khcc_div: bit-serial restoring divider
// Divides a 16-bit value by a DW-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module khcc_div import khcc_pkg::*; #(
  parameter int DW = MODU_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ACC_W-1:0] dividend_i,
  input  wire logic [DW-1:0]    divisor_i,
  output logic                  done_o,
  output logic [ACC_W-1:0]      quot_o,
  output logic [DW-1:0]         rem_o
);

  localparam int CW = $clog2(ACC_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [ACC_W-1:0] quot_q, quot_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [DW:0]      partial;
  logic [DW:0]      diff;

  // One restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    partial = {rem_q, quot_q[ACC_W-1]};
    diff    = partial - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(ACC_W - 1);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d  = diff[DW-1:0];
        quot_d = {quot_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d  = partial[DW-1:0];
        quot_d = {quot_q[ACC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- design/keyword_hash_collision_check_core.sv -----
// ----------------------------------------------------------------------------
// keyword_hash_collision_check_core: perfect hash collision checker
// Hashes a stream of keyword characters, tracks slot occupancy per set.
// ----------------------------------------------------------------------------
// Sequence: a character that does not close a word is accepted and then folded
//   in by a bit-serial multiply-accumulate; a word-closing character then adds
//   a divider load step, two passes of the shared serial divider (one step per
//   dividend bit plus hand-over) and a slot update step.
// Flow: a new character is accepted only once the previous one is through; the
//   slot update waits while a stalled receiver holds the result register.
// Reset: asynchronous; registers return to their defaults, bitmap is cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyword_hash_collision_check_core import khcc_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  khcc_cfg_if.sink    cfg,
  khcc_in_if.sink     char_in,
  khcc_out_if.source  res_out
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int MW  = ($clog2(SLOT_COUNT + 1) > MODU_W) ? $clog2(SLOT_COUNT + 1) : MODU_W;
  localparam int OW  = (SW > SLOT_W) ? SW : SLOT_W;
  localparam int SPW = ((SW + 1) > SPREAD_W) ? (SW + 1) : SPREAD_W;
  localparam int BCW = $clog2(CHAR_W);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  // Configuration registers
  logic [MULT_W-1:0] mult_q;
  logic [STEP_W-1:0] step_q;
  logic [OFFS_W-1:0] offs_q;
  logic [DIVR_W-1:0] divr_q;
  logic [MODU_W-1:0] modu_q;

  // Control and set state
  logic [2:0]            state_q, state_d;
  logic [BCW-1:0]        bit_q, bit_d;
  logic                  we_q, we_d;
  logic                  se_q, se_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [ACC_W-1:0]      pos_q, pos_d;
  logic [ACC_W-1:0]      mcand_q, mcand_d;
  logic [CHAR_W-1:0]     chsr_q, chsr_d;
  logic [SLOT_COUNT-1:0] occ_q, occ_d;
  logic [SW-1:0]         low_q, low_d;
  logic [SW-1:0]         high_q, high_d;
  logic                  coll_q, coll_d;

  // Output register
  logic                out_vld_q, out_vld_d;
  logic [SLOT_W-1:0]   o_slot_q, o_slot_d;
  logic                o_coll_q, o_coll_d;
  logic [SLOT_W-1:0]   o_low_q, o_low_d;
  logic [SLOT_W-1:0]   o_high_q, o_high_d;
  logic [SPREAD_W-1:0] o_spread_q, o_spread_d;
  logic                o_done_q, o_done_d;

  // Divider hookup
  logic             div_start;
  logic [ACC_W-1:0] div_dividend;
  logic [MW-1:0]    div_divisor;
  logic             div_done;
  logic [ACC_W-1:0] div_quot;
  logic [MW-1:0]    div_rem;

  // Misc
  logic [MW-1:0]  div_eff;
  logic [MW-1:0]  modx;
  logic [MW-1:0]  mod_eff;
  logic [SW-1:0]  slot;
  logic [SPW-1:0] spread_x;
  logic           out_free;

  assign cfg.ready     = 1'b1;
  assign char_in.ready = (state_q == S_IDLE);
  assign out_free      = !out_vld_q || res_out.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= MULT_RST;
      step_q <= STEP_RST;
      offs_q <= OFFS_RST;
      divr_q <= DIVR_RST;
      modu_q <= MODU_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CHAR_MULT:  mult_q <= cfg.data[MULT_W-1:0];
        REG_STEP_INC:   step_q <= cfg.data[STEP_W-1:0];
        REG_FINAL_OFFS: offs_q <= cfg.data[OFFS_W-1:0];
        REG_DIVISOR:    divr_q <= cfg.data[DIVR_W-1:0];
        REG_MODULUS:    modu_q <= cfg.data[MODU_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective divisor and modulus: zero acts as one, modulus saturates
  always_comb begin
    div_eff = (divr_q == '0) ? MW'(1) : MW'(divr_q);
    modx    = MW'(modu_q);
    if (modx == '0) begin
      mod_eff = MW'(1);
    end else if (modx > MW'(SLOT_COUNT)) begin
      mod_eff = MW'(SLOT_COUNT);
    end else begin
      mod_eff = modx;
    end
  end

  // Divider operands: first the offset accumulator, then the quotient
  always_comb begin
    div_start    = 1'b0;
    div_dividend = acc_q + ACC_W'(offs_q);
    div_divisor  = div_eff;
    if (state_q == S_PRE) begin
      div_start = 1'b1;
    end else if (state_q == S_DIV && div_done) begin
      div_start    = 1'b1;
      div_dividend = div_quot;
      div_divisor  = mod_eff;
    end
  end

  khcc_div #(
    .DW (MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign slot = div_rem[SW-1:0];

  // Sequencer, accumulator and set tracking
  always_comb begin
    state_d    = state_q;
    bit_d      = bit_q;
    we_d       = we_q;
    se_d       = se_q;
    acc_d      = acc_q;
    pos_d      = pos_q;
    mcand_d    = mcand_q;
    chsr_d     = chsr_q;
    occ_d      = occ_q;
    low_d      = low_q;
    high_d     = high_q;
    coll_d     = coll_q;
    out_vld_d  = out_vld_q && !res_out.ready;
    o_slot_d   = o_slot_q;
    o_coll_d   = o_coll_q;
    o_low_d    = o_low_q;
    o_high_d   = o_high_q;
    o_spread_d = o_spread_q;
    o_done_d   = o_done_q;
    spread_x   = '0;

    case (state_q)
      S_IDLE: begin
        if (char_in.valid) begin
          acc_d   = acc_q + pos_q;
          pos_d   = pos_q + ACC_W'(step_q);
          mcand_d = ACC_W'(mult_q);
          chsr_d  = char_in.char_code;
          we_d    = char_in.word_end;
          se_d    = char_in.set_end;
          bit_d   = '0;
          state_d = S_MUL;
        end
      end
      // One character bit per cycle, shift-and-add
      S_MUL: begin
        if (chsr_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = {mcand_q[ACC_W-2:0], 1'b0};
        chsr_d  = {1'b0, chsr_q[CHAR_W-1:1]};
        bit_d   = bit_q + BCW'(1);
        if (bit_q == BCW'(CHAR_W - 1)) begin
          state_d = (we_q || se_q) ? S_PRE : S_IDLE;
        end
      end
      // Divider takes the offset accumulator; the word restarts afresh
      S_PRE: begin
        acc_d   = '0;
        pos_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          state_d = S_UPD;
        end
      end
      // Mark the slot, or clear the set state at a set end, and load the result register
      S_UPD: begin
        if (out_free) begin
          o_coll_d = coll_q || occ_q[slot];
          o_low_d  = SLOT_W'(OW'((slot < low_q) ? slot : low_q));
          o_high_d = SLOT_W'(OW'((slot > high_q) ? slot : high_q));
          spread_x = SPW'((slot > high_q) ? slot : high_q)
                   - SPW'((slot < low_q) ? slot : low_q) + SPW'(1);
          o_spread_d = spread_x[SPREAD_W-1:0];
          o_slot_d   = SLOT_W'(OW'(slot));
          o_done_d   = se_q;
          out_vld_d  = 1'b1;
          if (se_q) begin
            occ_d  = '0;
            low_d  = SW'(SLOT_COUNT - 1);
            high_d = '0;
            coll_d = 1'b0;
          end else begin
            occ_d[slot] = 1'b1;
            coll_d      = coll_q || occ_q[slot];
            low_d       = (slot < low_q) ? slot : low_q;
            high_d      = (slot > high_q) ? slot : high_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bit_q     <= '0;
      we_q      <= 1'b0;
      se_q      <= 1'b0;
      acc_q     <= '0;
      pos_q     <= '0;
      occ_q     <= '0;
      low_q     <= SW'(SLOT_COUNT - 1);
      high_q    <= '0;
      coll_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_q     <= bit_d;
      we_q      <= we_d;
      se_q      <= se_d;
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      occ_q     <= occ_d;
      low_q     <= low_d;
      high_q    <= high_d;
      coll_q    <= coll_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mcand_q    <= mcand_d;
    chsr_q     <= chsr_d;
    o_slot_q   <= o_slot_d;
    o_coll_q   <= o_coll_d;
    o_low_q    <= o_low_d;
    o_high_q   <= o_high_d;
    o_spread_q <= o_spread_d;
    o_done_q   <= o_done_d;
  end

  assign res_out.valid        = out_vld_q;
  assign res_out.slot         = o_slot_q;
  assign res_out.collision    = o_coll_q;
  assign res_out.lowest_slot  = o_low_q;
  assign res_out.highest_slot = o_high_q;
  assign res_out.spread       = o_spread_q;
  assign res_out.set_done     = o_done_q;

endmodule

`default_nettype wire

// ----- tb/tb_keyword_hash_collision_check_core.sv -----
// ----------------------------------------------------------------------------
// tb_keyword_hash_collision_check_core: self-checking bench for the core
// Streams keyword sets through the character channel under several register
// settings and idle patterns. A behavioural hash model predicts one report per
// finished word; every report is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyword_hash_collision_check_core;
  import khcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 60;   // covers a word-closing item
  localparam int unsigned PHASE_CHARS   = 220;
  localparam int unsigned PHASE_COUNT   = 8;

  // Indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_MODULUS + 1'b1;
  localparam int unsigned SPARE_REGS = (1 << CFG_IDX_W) - REG_SPARE_LO;

  typedef enum int unsigned {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                collision;
    logic [SLOT_W-1:0]   lowest_slot;
    logic [SLOT_W-1:0]   highest_slot;
    logic [SPREAD_W-1:0] spread;
    logic                set_done;
  } word_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  khcc_cfg_if cfg ();
  khcc_in_if  char_in ();
  khcc_out_if res_out ();

  keyword_hash_collision_check_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg),
    .char_in (char_in),
    .res_out (res_out)
  );

  always #5 clk_i = ~clk_i;

  // Hash model: registers and per-set state
  logic [MULT_W-1:0]         reg_mult;
  logic [STEP_W-1:0]         reg_step;
  logic [OFFS_W-1:0]         reg_offs;
  logic [DIVR_W-1:0]         reg_divr;
  logic [MODU_W-1:0]         reg_modu;
  logic [ACC_W-1:0]          hash_acc;
  logic [ACC_W-1:0]          pos_term;
  logic [SLOT_COUNT_DEF-1:0] occupied;
  logic [SLOT_W-1:0]         low_mark;
  logic [SLOT_W-1:0]         high_mark;
  logic                      collided;

  word_report_t word_reports[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned chars_sent  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  function automatic void clear_set();
    hash_acc  = '0;
    pos_term  = '0;
    occupied  = '0;
    low_mark  = SLOT_W'(SLOT_COUNT_DEF - 1);
    high_mark = '0;
    collided  = 1'b0;
  endfunction

  function automatic void reset_model();
    reg_mult = MULT_RST;
    reg_step = STEP_RST;
    reg_offs = OFFS_RST;
    reg_divr = DIVR_RST;
    reg_modu = MODU_RST;
    clear_set();
  endfunction

  // Fold one character into the hash; a closing character queues a report
  function automatic void hash_char(input logic [CHAR_W-1:0] code, input logic we,
                                    input logic se);
    logic [ACC_W-1:0]  biased;
    logic [SLOT_W-1:0] slot_idx;
    int unsigned       dv, md, sl;
    word_report_t      rep;
    hash_acc = hash_acc + reg_mult * code + pos_term;
    pos_term = pos_term + reg_step;
    if (!we && !se) return;
    dv = (reg_divr == 0) ? 1 : reg_divr;
    md = (reg_modu == 0) ? 1 : reg_modu;
    if (md > SLOT_COUNT_DEF) md = SLOT_COUNT_DEF;
    biased = hash_acc + ACC_W'(reg_offs);
    sl = (32'(biased) / dv) % md;
    slot_idx = SLOT_W'(sl);
    if (occupied[slot_idx]) collided = 1'b1;
    occupied[slot_idx] = 1'b1;
    if (sl < low_mark) low_mark = SLOT_W'(sl);
    if (sl > high_mark) high_mark = SLOT_W'(sl);
    rep.slot         = SLOT_W'(sl);
    rep.collision    = collided;
    rep.lowest_slot  = low_mark;
    rep.highest_slot = high_mark;
    rep.spread       = {1'b0, high_mark} - {1'b0, low_mark} + 7'd1;
    rep.set_done     = se;
    word_reports.push_back(rep);
    hash_acc = '0;
    pos_term = '0;
    if (se) clear_set();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Report checker, oldest expectation first
  always @(posedge clk_i) begin
    word_report_t want;
    if (rst_ni && res_out.valid && res_out.ready) begin
      if (word_reports.size() == 0) begin
        $error("report with no word pending: slot %0d", res_out.slot);
        fail_count++;
      end else begin
        want = word_reports.pop_front();
        check_field("slot", 8'(want.slot), 8'(res_out.slot));
        check_field("collision", 8'(want.collision), 8'(res_out.collision));
        check_field("lowest_slot", 8'(want.lowest_slot), 8'(res_out.lowest_slot));
        check_field("highest_slot", 8'(want.highest_slot), 8'(res_out.highest_slot));
        check_field("spread", 8'(want.spread), 8'(res_out.spread));
        check_field("set_done", 8'(want.set_done), 8'(res_out.set_done));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** keyword_hash_collision_check_core: FAILED **");
      $finish;
    end
  end

  // Report receiver, stalls at random
  initial begin
    res_out.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      res_out.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 54; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 54; end
      default:       begin gap_pct = 21; stall_pct = 21; end
    endcase
  endfunction

  // Send one character item; returns at a falling edge with valid still high
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic we, input logic se);
    while ($urandom_range(99) < gap_pct) begin
      char_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_in.valid     <= 1'b1;
    char_in.char_code <= code;
    char_in.word_end  <= we;
    char_in.set_end   <= se;
    @(posedge clk_i);
    while (!char_in.ready) @(posedge clk_i);
    hash_char(code, we, se);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the character stream until every pending report is back
  task automatic drain_results();
    char_in.valid <= 1'b0;
    while (word_reports.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      REG_CHAR_MULT:  reg_mult = data[MULT_W-1:0];
      REG_STEP_INC:   reg_step = data[STEP_W-1:0];
      REG_FINAL_OFFS: reg_offs = data[OFFS_W-1:0];
      REG_DIVISOR:    reg_divr = data[DIVR_W-1:0];
      REG_MODULUS:    reg_modu = data[MODU_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Program all registers once the core has gone quiet; a spare index is hit too
  task automatic load_config(input logic [CFG_DATA_W-1:0] mult, input logic [CFG_DATA_W-1:0] step,
                             input logic [CFG_DATA_W-1:0] offs, input logic [CFG_DATA_W-1:0] divr,
                             input logic [CFG_DATA_W-1:0] modu);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(REG_CHAR_MULT, mult);
    write_reg(REG_STEP_INC, step);
    write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(SPARE_REGS - 1)),
              CFG_DATA_W'($urandom));
    write_reg(REG_FINAL_OFFS, offs);
    write_reg(REG_DIVISOR, divr);
    write_reg(REG_MODULUS, modu);
    cfg.valid <= 1'b0;
  endtask

  // Defaults after reset: plain sums mod 64, collisions and set clearing
  task automatic test_set_basics();
    send_char(8'h00, 1'b1, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);   // top slot, full spread
    send_char(8'h00, 1'b1, 1'b0);   // repeat slot
    send_char(8'hFF, 1'b0, 1'b1);   // set end closes the word by itself
    send_char("a", 1'b0, 1'b0);
    send_char("b", 1'b1, 1'b0);     // fresh set, no collision carried over
    send_char("b", 1'b0, 1'b0);
    send_char("a", 1'b1, 1'b0);
    send_char("z", 1'b1, 1'b1);
    send_char(8'h01, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 1'b1);
  endtask

  // Register extremes, masking of wide data, zero divisor and modulus
  task automatic test_register_corners();
    load_config(9'd511, 9'd255, 9'd31, 9'd32, 9'd127);   // modulus saturates
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b1);
    load_config(9'd0, 9'd1, 9'd0, 9'h1C0, 9'h180);        // masked to zero
    send_char(8'hA5, 1'b1, 1'b0);
    send_char(8'h5A, 1'b0, 1'b1);
    load_config(9'h101, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
    send_char(8'h3C, 1'b0, 1'b0);
    send_char(8'hC3, 1'b1, 1'b0);
    send_char(8'h7E, 1'b1, 1'b1);
  endtask

  // One keyword set, mostly well formed; now and then a run of loose flags
  task automatic send_random_set();
    int unsigned n_words, len;
    logic        last_w, last_s;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 1))
        send_char(CHAR_W'($urandom), 1'($urandom), $urandom_range(15) == 0);
    end else begin
      n_words = $urandom_range(16, 1);
      for (int unsigned w = 0; w < n_words; w++) begin
        // rare very long word so the position term wraps under a large step
        len = ($urandom_range(299) == 0) ? $urandom_range(300, 257) : $urandom_range(8, 1);
        for (int unsigned k = 0; k < len; k++) begin
          last_w = (k == len - 1);
          last_s = last_w && (w == n_words - 1);
          send_char(CHAR_W'($urandom), last_w && !(last_s && $urandom_range(1)), last_s);
        end
      end
    end
  endtask

  task automatic test_random_sets();
    int unsigned start;
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: load_config(9'd1, 9'd0, 9'd0, 9'd1, 9'd64);
        1: load_config(9'd511, 9'd255, 9'd31, 9'd32, 9'd64);
        2: load_config(9'd1, 9'd0, 9'd31, 9'd1, 9'd1);
        3, 4: load_config(CFG_DATA_W'($urandom_range(511, 1)),
                          CFG_DATA_W'($urandom_range(255)),
                          CFG_DATA_W'($urandom_range(31)),
                          CFG_DATA_W'($urandom_range(32, 1)),
                          CFG_DATA_W'($urandom_range(64, 1)));
        default: load_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom));
      endcase
      set_idling(idle_mode_e'(ph % 4));
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) begin
        send_random_set();
        if ($urandom_range(19) == 0) drain_results();
      end
      // close any word left open by loose flags
      send_char(CHAR_W'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  initial begin
    char_in.valid     <= 1'b0;
    char_in.char_code <= '0;
    char_in.word_end  <= 1'b0;
    char_in.set_end   <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= '0;
    cfg.data          <= '0;
    rst_ni            <= 1'b0;
    reset_model();
    set_idling(IDLE_NONE);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_set_basics();
    test_register_corners();
    test_random_sets();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("** keyword_hash_collision_check_core: PASSED **");
    else
      $display("** keyword_hash_collision_check_core: FAILED **");
    $finish;
  end

endmodule
